### hdl/clx_pkg.sv
`timescale 1ns / 1ps
// clx_pkg: token kinds, scanner modes, character codes and keyword constants
// shared by the c subset lexer; no dependencies
package clx_pkg;

  localparam int unsigned KIND_BITS  = 5;
  localparam int unsigned KW_BITS    = 48;
  localparam int unsigned KW_CHARS   = 6;
  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_PTR_BITS = $clog2(OUTQ_DEPTH);

  typedef enum logic [KIND_BITS-1:0] {
    K_NUMBER = 5'd0, K_NAME, K_STRING, K_INT, K_IF, K_ELSE, K_WHILE, K_FOR, K_PRINTF,
    K_PLUS, K_MINUS, K_MUL, K_DIV, K_MOD, K_EQ, K_NEQ, K_LT, K_GT, K_LEQ, K_GEQ,
    K_ASSIGN, K_INC, K_PLUSEQ, K_LPAREN, K_RPAREN, K_LBRACE, K_RBRACE, K_SEMI,
    K_COMMA, K_EOF
  } kind_e;

  typedef enum logic [5:0] {
    M_IDLE    = 6'b000001,
    M_NUMBER  = 6'b000010,
    M_NAME    = 6'b000100,
    M_STRING  = 6'b001000,
    M_COMMENT = 6'b010000,
    M_PENDING = 6'b100000
  } mode_e;

  // number of tokens written to the output queue in one cycle
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_D0     = 8'h30;
  localparam logic [7:0] CH_D9     = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // keywords, first character in the low byte
  localparam logic [KW_BITS-1:0] KW_INT    = 48'h0000_0074_6E69;
  localparam logic [KW_BITS-1:0] KW_IF     = 48'h0000_0000_6669;
  localparam logic [KW_BITS-1:0] KW_ELSE   = 48'h0000_6573_6C65;
  localparam logic [KW_BITS-1:0] KW_WHILE  = 48'h0065_6C69_6877;
  localparam logic [KW_BITS-1:0] KW_FOR    = 48'h0000_0072_6F66;
  localparam logic [KW_BITS-1:0] KW_PRINTF = 48'h6674_6E69_7270;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_D0) && (c <= CH_D9);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
  endfunction

  function automatic logic is_single(input logic [7:0] c);
    logic hit;
    case (c)
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_LT, CH_GT, CH_EQ,
      CH_LPAR, CH_RPAR, CH_LBRACE, CH_RBRACE, CH_SEMI, CH_COMMA: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic kind_e single_kind(input logic [7:0] c);
    kind_e k;
    unique case (c)
      CH_PLUS:   k = K_PLUS;
      CH_MINUS:  k = K_MINUS;
      CH_STAR:   k = K_MUL;
      CH_SLASH:  k = K_DIV;
      CH_PCT:    k = K_MOD;
      CH_LT:     k = K_LT;
      CH_GT:     k = K_GT;
      CH_EQ:     k = K_ASSIGN;
      CH_LPAR:   k = K_LPAREN;
      CH_RPAR:   k = K_RPAREN;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_SEMI:   k = K_SEMI;
      CH_COMMA:  k = K_COMMA;
      default:   k = K_PLUS;
    endcase
    return k;
  endfunction

  // characters that may open a two-character operator or a comment
  function automatic logic is_pending_start(input logic [7:0] c);
    return (c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT) ||
           (c == CH_PLUS) || (c == CH_SLASH);
  endfunction

  function automatic kind_e name_kind(input logic too_long, input logic [KW_BITS-1:0] kw);
    kind_e k;
    k = K_NAME;
    if (!too_long) begin
      if (kw == KW_INT) k = K_INT;
      else if (kw == KW_IF) k = K_IF;
      else if (kw == KW_ELSE) k = K_ELSE;
      else if (kw == KW_WHILE) k = K_WHILE;
      else if (kw == KW_FOR) k = K_FOR;
      else if (kw == KW_PRINTF) k = K_PRINTF;
    end
    return k;
  endfunction

endpackage

### hdl/clx_if.sv
`timescale 1ns / 1ps
// clx_in_if and clx_out_if: valid/ready channels of the lexer
// depends on clx_pkg
interface clx_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] char_byte;
  modport source (output valid, func, char_byte, input ready);
  modport sink (input valid, func, char_byte, output ready);
endinterface

interface clx_out_if import clx_pkg::*; #(
  parameter int unsigned LINE_BITS   = 16,
  parameter int unsigned OFFSET_BITS = 24,
  parameter int unsigned LENGTH_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [KIND_BITS-1:0]   token_kind;
  logic [LINE_BITS-1:0]   line_number;
  logic [OFFSET_BITS-1:0] start_offset;
  logic [LENGTH_BITS-1:0] token_length;
  logic                   last_of_run;
  modport source (output valid, token_kind, line_number, start_offset, token_length,
                  last_of_run, input ready);
  modport sink (input valid, token_kind, line_number, start_offset, token_length,
                last_of_run, output ready);
endinterface

### hdl/clx_core.sv
`timescale 1ns / 1ps
// clx_core: input register, scanner state and combinational token decision
// depends on clx_pkg and clx_in_if
module clx_core import clx_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 24,
  parameter int unsigned LINE_BITS   = 16,
  parameter int unsigned LENGTH_BITS = 16,
  localparam int unsigned TOK_BITS = KIND_BITS + LINE_BITS + OFFSET_BITS + LENGTH_BITS + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  clx_in_if.sink              in_i,
  input  logic                room_i,
  output push_t               push_o,
  output logic [TOK_BITS-1:0] tok0_o,
  output logic [TOK_BITS-1:0] tok1_o
);

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [LINE_BITS-1:0]   line;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] len;
    logic                   last;
  } tok_t;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};

  logic       in_v_q;
  logic       func_q;
  logic [7:0] char_q;
  logic       fire;

  mode_e                  mode_q, mode_d;
  logic [7:0]             pend_q, pend_d;
  logic [KW_BITS-1:0]     kw_q, kw_d;
  logic                   long_q, long_d;
  logic [OFFSET_BITS-1:0] tstart_q, tstart_d;
  logic [LENGTH_BITS-1:0] cnt_q, cnt_d;
  logic [OFFSET_BITS-1:0] byte_q, byte_d;
  logic [LINE_BITS-1:0]   line_q, line_d;

  logic [OFFSET_BITS-1:0] byte_inc;
  logic [LINE_BITS-1:0]   line_inc;
  logic [LENGTH_BITS-1:0] cnt_inc;

  logic                   fl_v, sec_v, go_idle;
  kind_e                  fl_kind, sec_kind, pair_kind;
  logic [OFFSET_BITS-1:0] fl_start, sec_start;
  logic [LENGTH_BITS-1:0] fl_len, sec_len;
  logic                   pair_v;
  tok_t                   fl_tok, sec_tok;

  assign fire       = in_v_q && room_i;
  assign in_i.ready = !in_v_q || room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_v_q <= 1'b1;
    end else if (fire) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      func_q <= in_i.func;
      char_q <= in_i.char_byte;
    end
  end

  assign byte_inc = (byte_q == OFF_MAX) ? byte_q : byte_q + OFFSET_BITS'(1);
  assign line_inc = (line_q == LINE_MAX) ? line_q : line_q + LINE_BITS'(1);
  assign cnt_inc  = (cnt_q == LEN_MAX) ? cnt_q : cnt_q + LENGTH_BITS'(1);

  // two-character operators from the pending character and this byte
  always_comb begin
    pair_v    = 1'b0;
    pair_kind = K_EQ;
    if (char_q == CH_EQ) begin
      pair_v = 1'b1;
      if (pend_q == CH_EQ) pair_kind = K_EQ;
      else if (pend_q == CH_BANG) pair_kind = K_NEQ;
      else if (pend_q == CH_LT) pair_kind = K_LEQ;
      else if (pend_q == CH_GT) pair_kind = K_GEQ;
      else if (pend_q == CH_PLUS) pair_kind = K_PLUSEQ;
      else pair_v = 1'b0;
    end else if ((char_q == CH_PLUS) && (pend_q == CH_PLUS)) begin
      pair_v    = 1'b1;
      pair_kind = K_INC;
    end
  end

  always_comb begin
    mode_d   = mode_q;
    pend_d   = pend_q;
    kw_d     = kw_q;
    long_d   = long_q;
    tstart_d = tstart_q;
    cnt_d    = cnt_q;
    byte_d   = byte_inc;
    line_d   = line_q;
    fl_v     = 1'b0;
    fl_kind  = K_NUMBER;
    fl_start = tstart_q;
    fl_len   = cnt_q;
    sec_v    = 1'b0;
    sec_kind = K_EOF;
    sec_start = byte_q;
    sec_len  = '0;
    go_idle  = 1'b0;
    if (func_q) begin
      unique case (mode_q)
        M_NUMBER: fl_v = 1'b1;
        M_NAME: begin
          fl_v    = 1'b1;
          fl_kind = name_kind(long_q, kw_q);
        end
        M_STRING: begin
          fl_v    = 1'b1;
          fl_kind = K_STRING;
        end
        M_PENDING: begin
          fl_v    = (pend_q != CH_BANG);
          fl_kind = single_kind(pend_q);
          fl_len  = LENGTH_BITS'(1);
        end
        default: ;
      endcase
      sec_v    = 1'b1;
      mode_d   = M_IDLE;
      pend_d   = '0;
      kw_d     = '0;
      long_d   = 1'b0;
      tstart_d = '0;
      cnt_d    = '0;
      byte_d   = '0;
      line_d   = LINE_BITS'(1);
    end else begin
      unique case (mode_q)
        M_NUMBER: begin
          if (is_digit(char_q)) begin
            cnt_d = cnt_inc;
          end else begin
            fl_v    = 1'b1;
            go_idle = 1'b1;
          end
        end
        M_NAME: begin
          if (is_alpha(char_q) || is_digit(char_q) || (char_q == CH_USCORE)) begin
            for (int k = 0; k < KW_CHARS; k++) begin
              if (cnt_q == LENGTH_BITS'(k)) kw_d[8*k +: 8] = char_q;
            end
            if (cnt_q >= LENGTH_BITS'(KW_CHARS)) long_d = 1'b1;
            cnt_d = cnt_inc;
          end else begin
            fl_v    = 1'b1;
            fl_kind = name_kind(long_q, kw_q);
            go_idle = 1'b1;
          end
        end
        M_STRING: begin
          if (char_q == CH_QUOTE) begin
            fl_v    = 1'b1;
            fl_kind = K_STRING;
            mode_d  = M_IDLE;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        M_COMMENT: begin
          if (char_q == CH_LF) begin
            line_d = line_inc;
            mode_d = M_IDLE;
          end
        end
        M_PENDING: begin
          if ((pend_q == CH_SLASH) && (char_q == CH_SLASH)) begin
            mode_d = M_COMMENT;
          end else if (pair_v) begin
            fl_v    = 1'b1;
            fl_kind = pair_kind;
            fl_len  = LENGTH_BITS'(2);
            mode_d  = M_IDLE;
          end else begin
            fl_v    = (pend_q != CH_BANG);
            fl_kind = single_kind(pend_q);
            fl_len  = LENGTH_BITS'(1);
            go_idle = 1'b1;
          end
        end
        default: go_idle = 1'b1;
      endcase
      if (go_idle) begin
        mode_d = M_IDLE;
        if (char_q == CH_LF) begin
          line_d = line_inc;
        end else if (char_q == CH_HASH) begin
          mode_d = M_COMMENT;
        end else if (char_q == CH_QUOTE) begin
          mode_d   = M_STRING;
          tstart_d = byte_inc;
          cnt_d    = '0;
        end else if (is_digit(char_q)) begin
          mode_d   = M_NUMBER;
          tstart_d = byte_q;
          cnt_d    = LENGTH_BITS'(1);
        end else if (is_alpha(char_q) || (char_q == CH_USCORE)) begin
          mode_d   = M_NAME;
          tstart_d = byte_q;
          kw_d     = {{(KW_BITS-8){1'b0}}, char_q};
          long_d   = 1'b0;
          cnt_d    = LENGTH_BITS'(1);
        end else if (is_pending_start(char_q)) begin
          mode_d   = M_PENDING;
          pend_d   = char_q;
          tstart_d = byte_q;
        end else if (is_single(char_q)) begin
          sec_v    = 1'b1;
          sec_kind = single_kind(char_q);
          sec_len  = LENGTH_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      pend_q   <= '0;
      kw_q     <= '0;
      long_q   <= 1'b0;
      tstart_q <= '0;
      cnt_q    <= '0;
      byte_q   <= '0;
      line_q   <= LINE_BITS'(1);
    end else if (fire) begin
      mode_q   <= mode_d;
      pend_q   <= pend_d;
      kw_q     <= kw_d;
      long_q   <= long_d;
      tstart_q <= tstart_d;
      cnt_q    <= cnt_d;
      byte_q   <= byte_d;
      line_q   <= line_d;
    end
  end

  assign fl_tok  = '{kind: fl_kind, line: line_q, start: fl_start, len: fl_len,
                     last: !sec_v};
  assign sec_tok = '{kind: sec_kind, line: line_q, start: sec_start, len: sec_len,
                     last: 1'b1};

  assign tok0_o        = fl_v ? fl_tok : sec_tok;
  assign tok1_o        = sec_tok;
  assign push_o.first  = fire && (fl_v || sec_v);
  assign push_o.second = fire && fl_v && sec_v;

endmodule

### hdl/clx_outq.sv
`timescale 1ns / 1ps
// clx_outq: four-entry token queue, up to two writes and one read per cycle
// depends on clx_pkg and clx_out_if
module clx_outq import clx_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 24,
  parameter int unsigned LINE_BITS   = 16,
  parameter int unsigned LENGTH_BITS = 16,
  localparam int unsigned TOK_BITS = KIND_BITS + LINE_BITS + OFFSET_BITS + LENGTH_BITS + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  push_t               push_i,
  input  logic [TOK_BITS-1:0] tok0_i,
  input  logic [TOK_BITS-1:0] tok1_i,
  output logic                room_o,
  clx_out_if.source           out_o
);

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [LINE_BITS-1:0]   line;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] len;
    logic                   last;
  } tok_t;

  localparam int unsigned CNT_BITS = OUTQ_PTR_BITS + 1;

  tok_t                     mem_q [OUTQ_DEPTH];
  logic [OUTQ_PTR_BITS-1:0] wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [CNT_BITS-1:0]      cnt_q, cnt_d;
  logic                     pop;
  tok_t                     head;

  assign pop     = out_o.valid && out_o.ready;
  assign wr_next = wr_q + OUTQ_PTR_BITS'(1);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i.second) begin
      wr_d  = wr_q + OUTQ_PTR_BITS'(2);
      cnt_d = cnt_d + CNT_BITS'(2);
    end else if (push_i.first) begin
      wr_d  = wr_next;
      cnt_d = cnt_d + CNT_BITS'(1);
    end
    if (pop) begin
      rd_d  = rd_q + OUTQ_PTR_BITS'(1);
      cnt_d = cnt_d - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first) mem_q[wr_q] <= tok0_i;
    if (push_i.second) mem_q[wr_next] <= tok1_i;
  end

  assign room_o = (cnt_q <= CNT_BITS'(OUTQ_DEPTH - 2));

  assign head               = mem_q[rd_q];
  assign out_o.valid        = (cnt_q != '0);
  assign out_o.token_kind   = head.kind;
  assign out_o.line_number  = head.line;
  assign out_o.start_offset = head.start;
  assign out_o.token_length = head.len;
  assign out_o.last_of_run  = head.last;

endmodule

### hdl/c_subset_lexer_unit.sv
`timescale 1ns / 1ps
// c_subset_lexer_unit: streaming tokenizer for a small c subset
// depends on clx_pkg, clx_if, clx_core and clx_outq
//
// in_i carries one source byte per transfer (func 0) or the end of the
// source (func 1). out_o carries tokens: kind, start line, start byte
// offset, length and last_of_run, which marks the final token of a byte.
// A byte yields zero, one or two tokens; the end item yields any pending
// token and then EOF, after which a new source starts at line 1.
// A byte waits in the input register until the queue has room; it is then
// decided and its tokens are written to the queue, whose head drives out_o.
// Throughput: one byte per cycle while out_o takes a token per cycle; the
// four-entry output queue absorbs bytes that give two tokens.
// When out_o stalls, the queue fills and in_i.ready drops once fewer than
// two entries are free and the input register holds a byte.
// Reset clears the scanner to line 1, offset 0 and empties the queue.
module c_subset_lexer_unit import clx_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 24,
  parameter int unsigned LINE_BITS   = 16,
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  clx_in_if.sink    in_i,
  clx_out_if.source out_o
);

  localparam int unsigned TOK_BITS = KIND_BITS + LINE_BITS + OFFSET_BITS + LENGTH_BITS + 1;

  push_t               push;
  logic                room;
  logic [TOK_BITS-1:0] tok0, tok1;

  clx_core #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .room_i (room),
    .push_o (push),
    .tok0_o (tok0),
    .tok1_o (tok1)
  );

  clx_outq #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .tok0_i (tok0),
    .tok1_i (tok1),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule
